FILE: hdl/ddss_pkg.sv
// Shared types, codes and defaults for the deadlock detection block.
// Used by ddss_alu, ddss_ctrl and the top level; depends on nothing.
package ddss_pkg;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 8;
  localparam int DEF_AMOUNT_BITS   = 16;

  localparam int ACTION_W   = 2;
  localparam int PROC_SEL_W = 4;
  localparam int RES_SEL_W  = 3;
  localparam int AMOUNT_W   = 16;
  localparam int SEQ_W      = 4;
  localparam int PCOUNT_W   = 5;
  localparam int RCOUNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;
  localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_ALLOC = 2'd0,
    ACT_LOAD_REQ   = 2'd1,
    ACT_LOAD_AVAIL = 2'd2,
    ACT_START      = 2'd3
  } ddss_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOLD_RD,
    ST_HOLD_CHK,
    ST_SCAN,
    ST_FIT_RD,
    ST_FIT_CHK,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_EMIT_SEQ,
    ST_EMIT_VERD
  } ddss_state_e;

  typedef struct packed {
    logic gt;
    logic nz;
  } ddss_flags_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_process;
    logic             is_verdict;
    logic             system_safe;
    logic             last;
  } ddss_out_t;

endpackage

FILE: hdl/ddss_ram.sv
// Single write port, single read port matrix memory with registered read data.
// Holds the allocation or the request matrix; no dependencies.
module ddss_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 128,
  parameter int ADW   = 7
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [ADW-1:0] waddr_i,
  input  logic [DW-1:0]  wdata_i,
  input  logic [ADW-1:0] raddr_i,
  output logic [DW-1:0]  rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ddss_alu.sv
// Shared compare and add unit: request against available, available plus
// allocation, and the nonzero test. Depends on ddss_pkg.
module ddss_alu import ddss_pkg::*; #(
  parameter int AVW = 21,
  parameter int AW  = 16
) (
  input  logic [AVW-1:0] a_i,
  input  logic [AW-1:0]  b_i,
  output logic [AVW-1:0] sum_o,
  output ddss_flags_t    flags_o
);

  logic [AVW-1:0] b_ext;

  assign b_ext      = AVW'(b_i);
  assign sum_o      = a_i + b_ext;
  assign flags_o.gt = b_ext > a_i;
  assign flags_o.nz = |b_i;

endmodule

FILE: hdl/ddss_ctrl.sv
// Check sequencer: counters, available vector, finished mask and output word.
// Drives the shared unit and the matrix read address. Depends on ddss_pkg.
module ddss_ctrl import ddss_pkg::*; #(
  parameter int MAX_P = 16,
  parameter int MAX_R = 8,
  parameter int AW    = 16,
  parameter int AVW   = 21,
  parameter int PW    = 4,
  parameter int RW    = 3,
  parameter int ADW   = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PCOUNT_W-1:0] pcount_i,
  input  logic [RCOUNT_W-1:0] rcount_i,
  input  logic                avail_we_i,
  input  logic [RW-1:0]       avail_idx_i,
  input  logic [AW-1:0]       avail_data_i,
  output logic [ADW-1:0]      raddr_o,
  input  logic [AW-1:0]       alloc_rdata_i,
  input  logic [AW-1:0]       req_rdata_i,
  output logic [AVW-1:0]      alu_a_o,
  output logic [AW-1:0]       alu_b_o,
  input  logic [AVW-1:0]      alu_sum_i,
  input  ddss_flags_t         alu_flags_i,
  output logic                idle_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ddss_out_t           out_o
);

  ddss_state_e    state_q, state_d;
  logic [PW-1:0]  p_q, p_d, np_m1_q, np_m1_d;
  logic [RW-1:0]  r_q, r_d, nr_m1_q, nr_m1_d;
  logic           holds_q, holds_d;
  logic [MAX_P-1:0] fin_q, fin_d;
  logic [AVW-1:0] avail_q [MAX_R];
  logic           av_we;
  logic [RW-1:0]  av_idx;
  logic [AVW-1:0] av_wdata;
  logic           out_valid_q, out_valid_d, out_load;
  ddss_out_t      out_q, out_d;
  logic           out_free, p_end, r_end, holds_n, all_fin;
  int             np_int, nr_int;

  assign out_free = !out_valid_q || out_ready_i;
  assign p_end    = p_q == np_m1_q;
  assign r_end    = r_q == nr_m1_q;
  assign raddr_o  = ADW'(ADW'(p_q) * ADW'(MAX_R) + ADW'(r_q));
  assign alu_a_o  = avail_q[r_q];
  assign alu_b_o  = (state_q == ST_FIT_CHK) ? req_rdata_i : alloc_rdata_i;
  assign holds_n  = holds_q | alu_flags_i.nz;
  assign idle_o   = state_q == ST_IDLE;

  always_comb begin
    np_int = int'(pcount_i);
    if (np_int < 1) np_int = 1;
    if (np_int > MAX_P) np_int = MAX_P;
    nr_int = int'(rcount_i);
    if (nr_int < 1) nr_int = 1;
    if (nr_int > MAX_R) nr_int = MAX_R;
  end

  always_comb begin
    all_fin = 1'b1;
    for (int i = 0; i < MAX_P; i++) begin
      if (i <= int'(np_m1_q) && !fin_q[i]) all_fin = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    r_d      = r_q;
    np_m1_d  = np_m1_q;
    nr_m1_d  = nr_m1_q;
    holds_d  = holds_q;
    fin_d    = fin_q;
    av_we    = avail_we_i;
    av_idx   = avail_idx_i;
    av_wdata = AVW'(avail_data_i);
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          np_m1_d = PW'(np_int - 1);
          nr_m1_d = RW'(nr_int - 1);
          fin_d   = '0;
          p_d     = '0;
          r_d     = '0;
          holds_d = 1'b0;
          state_d = ST_HOLD_RD;
        end
      end
      ST_HOLD_RD: state_d = ST_HOLD_CHK;
      ST_HOLD_CHK: begin
        if (r_end) begin
          fin_d[p_q] = !holds_n;
          holds_d    = 1'b0;
          r_d        = '0;
          if (p_end) begin
            p_d     = '0;
            state_d = ST_SCAN;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = ST_HOLD_RD;
          end
        end else begin
          holds_d = holds_n;
          r_d     = r_q + 1'b1;
          state_d = ST_HOLD_RD;
        end
      end
      ST_SCAN: begin
        r_d = '0;
        if (!fin_q[p_q]) begin
          state_d = ST_FIT_RD;
        end else if (p_end) begin
          state_d = ST_EMIT_VERD;
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      ST_FIT_RD: state_d = ST_FIT_CHK;
      ST_FIT_CHK: begin
        if (alu_flags_i.gt) begin
          r_d = '0;
          if (p_end) begin
            state_d = ST_EMIT_VERD;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = ST_SCAN;
          end
        end else if (r_end) begin
          r_d     = '0;
          state_d = ST_ADD_RD;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = ST_FIT_RD;
        end
      end
      ST_ADD_RD: state_d = ST_ADD_CHK;
      ST_ADD_CHK: begin
        av_we    = 1'b1;
        av_idx   = r_q;
        av_wdata = alu_sum_i;
        if (r_end) begin
          state_d = ST_EMIT_SEQ;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = ST_ADD_RD;
        end
      end
      ST_EMIT_SEQ: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.seq_process = SEQ_W'(p_q);
          out_d.is_verdict  = 1'b0;
          out_d.system_safe = 1'b0;
          out_d.last        = 1'b0;
          fin_d[p_q]        = 1'b1;
          p_d               = '0;
          r_d               = '0;
          state_d           = ST_SCAN;
        end
      end
      ST_EMIT_VERD: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.seq_process = '0;
          out_d.is_verdict  = 1'b1;
          out_d.system_safe = all_fin;
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      r_q         <= '0;
      np_m1_q     <= '0;
      nr_m1_q     <= '0;
      holds_q     <= 1'b0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      r_q         <= r_d;
      np_m1_q     <= np_m1_d;
      nr_m1_q     <= nr_m1_d;
      holds_q     <= holds_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (av_we) begin
      avail_q[av_idx] <= av_wdata;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hdl/deadlock_detection_safe_sequence.sv
// Top level of the deadlock detection block: configuration registers, load
// decode, matrix memories, shared unit and sequencer.
// Depends on ddss_pkg, ddss_ram, ddss_alu and ddss_ctrl.
//
// Usage: configure process_count (index 0) and resource_count (index 1)
// through the write port while idle. Input words with action load
// allocation, load request or load available write one element each if
// the selects are in range; they are taken one per cycle while idle and
// give no result. A start word runs the check, and ready stays low until
// its verdict word is in the output register. The check yields one word
// per process in the safe sequence, then a verdict word with last set.
// Steps: with P processes and R resources in use, the holding pass reads
// all P*R allocation elements, each in a read and a check state; each round
// scans up to P processes, compares each request of an unfinished process
// with available in a read and a check state, returns its allocation in a
// read and an add state per resource and emits it. Each element passes
// in turn through the single compare/add unit and a matrix read port.
// Reset clears the finished mask and the output valid; the registers take
// 16 and 8. The matrices and the available vector hold no reset value.
// When the receiver stalls, the output word holds and the sequencer waits
// before emitting the next one.
module deadlock_detection_safe_sequence import ddss_pkg::*; #(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [PROC_SEL_W-1:0] proc_sel_i,
  input  logic [RES_SEL_W-1:0]  res_sel_i,
  input  logic [AMOUNT_W-1:0]   amount_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SEQ_W-1:0]      seq_process_o,
  output logic                  is_verdict_o,
  output logic                  system_safe_o,
  output logic                  last_o
);

  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AVW   = AMOUNT_BITS + $clog2(MAX_PROCESSES + 2);

  logic [PCOUNT_W-1:0] pcount_q;
  logic [RCOUNT_W-1:0] rcount_q;
  logic                in_fire, ps_ok, rs_ok, idle;
  logic                alloc_we, req_we, avail_we;
  logic [AMOUNT_BITS-1:0] amt;
  logic [ADW-1:0]      waddr, raddr;
  logic [AMOUNT_BITS-1:0] alloc_rdata, req_rdata, alu_b;
  logic [AVW-1:0]      alu_a, alu_sum;
  ddss_flags_t         alu_flags;
  ddss_out_t           out_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= PCOUNT_RESET;
      rcount_q <= RCOUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PROCESS_COUNT) begin
        pcount_q <= cfg_data_i[PCOUNT_W-1:0];
      end else if (cfg_idx_i == REG_RESOURCE_COUNT) begin
        rcount_q <= cfg_data_i[RCOUNT_W-1:0];
      end
    end
  end

  assign in_ready_o = idle;
  assign in_fire    = in_valid_i && idle;
  assign ps_ok      = 32'(proc_sel_i) < 32'(MAX_PROCESSES);
  assign rs_ok      = 32'(res_sel_i) < 32'(MAX_RESOURCES);
  assign amt        = AMOUNT_BITS'(32'(amount_i));
  assign waddr      = ADW'(32'(proc_sel_i) * 32'(MAX_RESOURCES) + 32'(res_sel_i));
  assign alloc_we   = in_fire && action_i == ACT_LOAD_ALLOC && ps_ok && rs_ok;
  assign req_we     = in_fire && action_i == ACT_LOAD_REQ && ps_ok && rs_ok;
  assign avail_we   = in_fire && action_i == ACT_LOAD_AVAIL && rs_ok;

  ddss_ram #(.DW(AMOUNT_BITS), .DEPTH(DEPTH), .ADW(ADW)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .waddr_i (waddr),
    .wdata_i (amt),
    .raddr_i (raddr),
    .rdata_o (alloc_rdata)
  );

  ddss_ram #(.DW(AMOUNT_BITS), .DEPTH(DEPTH), .ADW(ADW)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .waddr_i (waddr),
    .wdata_i (amt),
    .raddr_i (raddr),
    .rdata_o (req_rdata)
  );

  ddss_alu #(.AVW(AVW), .AW(AMOUNT_BITS)) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

  ddss_ctrl #(
    .MAX_P (MAX_PROCESSES),
    .MAX_R (MAX_RESOURCES),
    .AW    (AMOUNT_BITS),
    .AVW   (AVW),
    .PW    (PW),
    .RW    (RW),
    .ADW   (ADW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_fire && action_i == ACT_START),
    .pcount_i      (pcount_q),
    .rcount_i      (rcount_q),
    .avail_we_i    (avail_we),
    .avail_idx_i   (RW'(res_sel_i)),
    .avail_data_i  (amt),
    .raddr_o       (raddr),
    .alloc_rdata_i (alloc_rdata),
    .req_rdata_i   (req_rdata),
    .alu_a_o       (alu_a),
    .alu_b_o       (alu_b),
    .alu_sum_i     (alu_sum),
    .alu_flags_i   (alu_flags),
    .idle_o        (idle),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_word)
  );

  assign seq_process_o = out_word.seq_process;
  assign is_verdict_o  = out_word.is_verdict;
  assign system_safe_o = out_word.system_safe;
  assign last_o        = out_word.last;

endmodule
